// ===== design/fir_filter_circular_delay_defines.svh =====
// ----------------------------------------------------------------------------
// fir filter assertion macros
// shared property wrappers for the fir filter design files
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CIRCULAR_DELAY_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_DELAY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FIRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FIRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/firc_pkg.sv =====
// ----------------------------------------------------------------------------
// fir filter package
// payload types, control structs and fixed constants of the fir filter
// ----------------------------------------------------------------------------
package firc_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 16;
   localparam int COEF_IDX_W  = 6;
   localparam int TAP_COUNT_W = 7;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int FRAC_BITS   = 15;

   // request operations
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   // register reset value and saturation limits
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd1;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [TAP_COUNT_W-1:0] tap_count_type;

   typedef struct packed {
      logic                  operation;
      logic [COEF_IDX_W-1:0] coef_index;
      sample_type            coef_value;
      sample_type            sample;
   } req_type;

   typedef struct packed {
      sample_type filtered;
      logic       saturated;
   } rsp_type;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic rotate;
      logic coef_write;
   } cell_ctrl_type;

   // multiply-accumulate control
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic tap_live;
   } mac_ctrl_type;

endpackage

// ===== design/firc_if.sv =====
// ----------------------------------------------------------------------------
// fir filter channel interfaces
// valid/ready channels for requests, responses and the tap count register
// ----------------------------------------------------------------------------
interface firc_req_if;
   logic              valid;
   logic              ready;
   firc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface firc_rsp_if;
   logic              valid;
   logic              ready;
   firc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface firc_csr_if;
   logic                    valid;
   logic                    ready;
   firc_pkg::tap_count_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/firc_cell.sv =====
// ----------------------------------------------------------------------------
// fir filter delay cell
// holds one delayed sample and its coefficient; shifts on a new sample and
// rotates sample and coefficient together towards the head while filtering
// ----------------------------------------------------------------------------
module firc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  firc_pkg::cell_ctrl_type ctrl,
   input  firc_pkg::sample_type    shift_in,
   input  firc_pkg::sample_type    rot_samp_in,
   input  firc_pkg::sample_type    rot_coef_in,
   input  firc_pkg::sample_type    coef_wdata,
   output firc_pkg::sample_type    samp_out,
   output firc_pkg::sample_type    coef_out
);

   firc_pkg::sample_type samp_ff, samp_in;
   firc_pkg::sample_type coef_ff, coef_in;

   // next sample and coefficient
   always_comb begin
      samp_in = samp_ff;
      coef_in = coef_ff;
      if (ctrl.shift) begin
         samp_in = shift_in;
      end else if (ctrl.rotate) begin
         samp_in = rot_samp_in;
         coef_in = rot_coef_in;
      end
      if (ctrl.coef_write) begin
         coef_in = coef_wdata;
      end
   end

   // cell storage, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         samp_ff <= '0;
         coef_ff <= '0;
      end else begin
         samp_ff <= samp_in;
         coef_ff <= coef_in;
      end
   end

   assign samp_out = samp_ff;
   assign coef_out = coef_ff;

endmodule

// ===== design/firc_mac.sv =====
// ----------------------------------------------------------------------------
// fir filter multiply-accumulate
// one registered multiplier, a wide accumulator and q15 scaling with
// saturation to 16 bits
// ----------------------------------------------------------------------------
module firc_mac #(
   parameter int ACC_W = 38
) (
   input  logic                   clock,
   input  logic                   reset,
   input  firc_pkg::mac_ctrl_type ctrl,
   input  firc_pkg::sample_type   coef,
   input  firc_pkg::sample_type   samp,
   output firc_pkg::rsp_type      result
);

   localparam int HI_LSB = firc_pkg::FRAC_BITS + firc_pkg::SAMPLE_W - 1;

   logic signed [firc_pkg::PROD_W-1:0] prod_full;
   logic signed [firc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               prod_vld_ff;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic [ACC_W-HI_LSB-1:0]            acc_hi;
   logic                               clip;

   // product stage, taps beyond the tap count add nothing
   assign prod_full = coef * samp;
   assign prod_in   = ctrl.tap_live ? prod_full : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // scale by 2^-15 (floor) and clip to 16 bits
   assign acc_hi = acc_ff[ACC_W-1:HI_LSB];
   assign clip   = !((&acc_hi) || !(|acc_hi));

   always_comb begin
      result.saturated = clip;
      if (clip) begin
         result.filtered = acc_ff[ACC_W-1] ? firc_pkg::SAT_MIN : firc_pkg::SAT_MAX;
      end else begin
         result.filtered = acc_ff[HI_LSB:firc_pkg::FRAC_BITS];
      end
   end

endmodule

// ===== design/fir_filter_circular_delay.sv =====
// Requests are taken only while idle; coefficient requests are taken one per cycle.
// A sample request starts a pass, and no request is taken until its response is loaded.
// Each pass uses the single multiplier, fed one tap per cycle from the head
// of the rotating cell row, which turns once fully (TAPS steps) per sample.
// Reset (synchronous, active high) clears delay line, coefficients and the response
// valid flag, and sets the tap count to one.
// ----------------------------------------------------------------------------
// direct form fir filter
// row of delay cells holding samples and coefficients, rotated past one
// multiply-accumulate unit; q15 scaled, saturated 16-bit output
// ----------------------------------------------------------------------------
`include "fir_filter_circular_delay_defines.svh"

module fir_filter_circular_delay #(
   parameter int TAPS = 64
) (
   input logic        clock,
   input logic        reset,
   firc_req_if.sink   req,
   firc_rsp_if.source rsp,
   firc_csr_if.sink   csr
);

   localparam int CNT_W = $clog2(TAPS);
   localparam int CMP_W = ((CNT_W > firc_pkg::TAP_COUNT_W) ? CNT_W : firc_pkg::TAP_COUNT_W) + 1;
   localparam int IDX_W = ((CNT_W > firc_pkg::COEF_IDX_W) ? CNT_W : firc_pkg::COEF_IDX_W) + 1;
   localparam int ACC_W = firc_pkg::PROD_W + CNT_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    cnt_last;
   firc_pkg::tap_count_type tap_count_ff, tap_count_in;
   logic                    req_accept;
   logic                    sample_accept;
   logic                    coef_accept;
   logic                    rsp_free;
   logic                    rsp_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   firc_pkg::rsp_type       rsp_data_ff;
   firc_pkg::rsp_type       mac_result;
   firc_pkg::mac_ctrl_type  mac_ctrl;

   firc_pkg::cell_ctrl_type cell_ctrl [TAPS];
   firc_pkg::sample_type    cell_samp [TAPS];
   firc_pkg::sample_type    cell_coef [TAPS];

   // request handshake
   assign req.ready     = (state_ff == ST_IDLE);
   assign req_accept    = req.valid && req.ready;
   assign sample_accept = req_accept && (req.payload.operation == firc_pkg::OP_FILTER);
   assign coef_accept   = req_accept && (req.payload.operation == firc_pkg::OP_COEF);

   // tap count register
   assign csr.ready    = 1'b1;
   assign tap_count_in = (csr.valid && csr.ready) ? csr.payload : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= firc_pkg::TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // row of delay cells, cell k holds the sample k steps back
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      firc_pkg::sample_type shift_src;

      if (k == 0) begin : g_head
         assign shift_src = req.payload.sample;
      end else begin : g_body
         assign shift_src = cell_samp[k-1];
      end

      assign cell_ctrl[k] = '{
         shift:      sample_accept,
         rotate:     (state_ff == ST_RUN),
         coef_write: coef_accept && (IDX_W'(req.payload.coef_index) == IDX_W'(k))
      };

      firc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[k]),
         .shift_in    (shift_src),
         .rot_samp_in (cell_samp[(k + 1) % TAPS]),
         .rot_coef_in (cell_coef[(k + 1) % TAPS]),
         .coef_wdata  (req.payload.coef_value),
         .samp_out    (cell_samp[k]),
         .coef_out    (cell_coef[k])
      );
   end

   // tap counter
   assign cnt_last = (cnt_ff == CNT_W'(TAPS - 1));

   always_comb begin
      cnt_in = '0;
      if ((state_ff == ST_RUN) && !cnt_last) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // sequencer
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // multiply-accumulate on the head cell
   assign mac_ctrl = '{
      clear:    sample_accept,
      mul_en:   (state_ff == ST_RUN),
      tap_live: (CMP_W'(cnt_ff) < CMP_W'(tap_count_ff))
   };

   firc_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (cell_coef[0]),
      .samp   (cell_samp[0]),
      .result (mac_result)
   );

   // response register
   assign rsp_load     = (state_ff == ST_FINISH) && rsp_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // checks
   `FIRC_ASSERT_NEXT(a_start_run, clock, reset, sample_accept, (state_ff == ST_RUN) && (cnt_ff == '0), "sample request did not start a pass at tap zero")
   `FIRC_ASSERT_NEXT(a_run_end, clock, reset, (state_ff == ST_RUN) && cnt_last, (state_ff == ST_DRAIN) ##1 (state_ff == ST_FINISH), "pass end did not drain then finish")
   `FIRC_ASSERT_NOW(a_idle_home, clock, reset, state_ff != ST_RUN, cnt_ff == '0, "tap counter not home outside a pass")
   `FIRC_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "response raised without a finished pass")

endmodule

// ===== verif/fir_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir filter checker
// watches the request, response and tap count channels, keeps its own
// delay line, coefficient bank and tap count, works out the filter output
// of each sample request and compares it with the response that comes out
// ----------------------------------------------------------------------------
module fir_filter_checker #(
   parameter int TAPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   firc_req_if         req_mon,
   firc_rsp_if         rsp_mon,
   firc_csr_if         csr_mon,
   output int unsigned outstanding,
   output int unsigned fail_count,
   output int unsigned checked_count,
   output int unsigned clipped_count
);

   // mirror of the filter state
   firc_pkg::sample_type    history [TAPS];
   firc_pkg::sample_type    coef_bank [TAPS];
   int unsigned             wr_pos;
   firc_pkg::tap_count_type taps_in_use;

   // filter outputs still owed by the block, oldest first
   firc_pkg::rsp_type       outputs_due [$];

   // store one sample and form the scaled, clipped sum over the live taps
   function automatic firc_pkg::rsp_type filter_sample(input firc_pkg::sample_type fresh);
      longint            acc;
      longint            scaled;
      int unsigned       live;
      int unsigned       pos;
      firc_pkg::rsp_type out;
      history[wr_pos] = fresh;
      wr_pos = (wr_pos + 1) % TAPS;
      live = (taps_in_use > TAPS) ? TAPS : taps_in_use;
      pos = (wr_pos + TAPS - 1) % TAPS;
      acc = 0;
      for (int k = 0; k < live; k++) begin
         acc += longint'(coef_bank[k]) * longint'(history[pos]);
         pos = (pos + TAPS - 1) % TAPS;
      end
      // q15 scaling rounds toward minus infinity
      scaled = acc >>> firc_pkg::FRAC_BITS;
      out.saturated = 1'b0;
      if (scaled > longint'(firc_pkg::SAT_MAX)) begin
         scaled = longint'(firc_pkg::SAT_MAX);
         out.saturated = 1'b1;
      end else if (scaled < longint'(firc_pkg::SAT_MIN)) begin
         scaled = longint'(firc_pkg::SAT_MIN);
         out.saturated = 1'b1;
      end
      out.filtered = firc_pkg::sample_type'(scaled);
      return out;
   endfunction

   always @(posedge clock) begin
      firc_pkg::rsp_type got;
      firc_pkg::rsp_type want;
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            history[k]   = '0;
            coef_bank[k] = '0;
         end
         wr_pos        = 0;
         taps_in_use   = firc_pkg::TAP_COUNT_RESET;
         fail_count    = 0;
         checked_count = 0;
         clipped_count = 0;
         outputs_due.delete();
      end else begin
         // response side first: a response can never belong to a request taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (outputs_due.size() == 0) begin
               $error("response with no sample outstanding: filtered %0d saturated %0b",
                      got.filtered, got.saturated);
               fail_count++;
            end else begin
               want = outputs_due.pop_front();
               checked_count++;
               if (want.saturated) clipped_count++;
               if (got.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
                  fail_count++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                  fail_count++;
               end
            end
         end

         // tap count register write
         if (csr_mon.valid && csr_mon.ready) taps_in_use = csr_mon.payload;

         // request side
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.payload.operation == firc_pkg::OP_COEF) begin
               if (req_mon.payload.coef_index < TAPS)
                  coef_bank[req_mon.payload.coef_index] = req_mon.payload.coef_value;
            end else begin
               outputs_due.push_back(filter_sample(req_mon.payload.sample));
            end
         end
      end
      outstanding <= outputs_due.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir filter testbench
// a short directed run over the corner cases, then random phases, each with
// its own tap count, coefficient set and sample shape; both channels idle
// in random bursts and the checker beside the filter predicts every output
// ----------------------------------------------------------------------------
module tb;

   localparam int TAPS        = 64;
   localparam int ITEM_TARGET = 1350;
   localparam int QUIET_ITEMS = 150;
   localparam int LONG_HOLD   = 600;
   localparam int SETTLE      = TAPS + 6;
   localparam int CYCLE_LIMIT = 1000000;

   // value shapes used for coefficients and samples
   typedef enum int {
      SHAPE_FULL,
      SHAPE_HIGH,
      SHAPE_LOW,
      SHAPE_SMALL,
      SHAPE_CORNER
   } shape_type;

   typedef logic [firc_pkg::COEF_IDX_W-1:0] coef_idx_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned checked_count;
   int unsigned clipped_count;

   int unsigned samples_sent  = 0;
   int unsigned coefs_sent    = 0;
   int unsigned settings_used = 0;
   int unsigned gap_odds      = 0;
   bit          quiet_tail    = 1'b0;
   bit          long_hold_req = 1'b0;

   firc_req_if req_ch ();
   firc_rsp_if rsp_ch ();
   firc_csr_if csr_ch ();

   fir_filter_circular_delay #(
      .TAPS(TAPS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   fir_filter_checker #(
      .TAPS(TAPS)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .outstanding   (outstanding),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .clipped_count (clipped_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("FAIL fir_filter_circular_delay");
         $finish;
      end
   end

   // one 16-bit word of the given shape
   function automatic firc_pkg::sample_type word_of_shape(input shape_type s);
      case (s)
         SHAPE_HIGH:
            return firc_pkg::SAT_MAX - firc_pkg::sample_type'($urandom_range(0, 1023));
         SHAPE_LOW:
            return firc_pkg::SAT_MIN + firc_pkg::sample_type'($urandom_range(0, 1023));
         SHAPE_SMALL:
            return firc_pkg::sample_type'($urandom_range(0, 511)) - 16'sd256;
         SHAPE_CORNER: begin
            case ($urandom_range(0, 4))
               0:       return firc_pkg::SAT_MAX;
               1:       return firc_pkg::SAT_MIN;
               2:       return 16'sd0;
               3:       return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default:     return firc_pkg::sample_type'($urandom);
      endcase
   endfunction

   // tap count of a random phase: the corners first, then mostly in range
   function automatic firc_pkg::tap_count_type phase_taps(input int unsigned n);
      case (n)
         0:       return 7'd64;
         1:       return 7'd0;
         2:       return 7'd127;
         3:       return 7'd65;
         4:       return 7'd1;
         5:       return 7'd2;
         6:       return 7'd63;
         default: begin
            if ($urandom_range(0, 3) == 0)
               return firc_pkg::tap_count_type'($urandom_range(0, 127));
            return firc_pkg::tap_count_type'($urandom_range(1, TAPS));
         end
      endcase
   endfunction

   // random gap on the request side
   task automatic pause_sender();
      if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // offer one request and wait for it to be taken
   task automatic offer(input firc_pkg::req_type item);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (item.operation == firc_pkg::OP_COEF) coefs_sent++;
      else samples_sent++;
      if (!quiet_tail && samples_sent + coefs_sent >= ITEM_TARGET - QUIET_ITEMS)
         quiet_tail <= 1'b1;
      pause_sender();
   endtask

   task automatic send_sample(input firc_pkg::sample_type value);
      firc_pkg::req_type item;
      item.operation  = firc_pkg::OP_FILTER;
      item.coef_index = coef_idx_type'($urandom_range(0, 63));
      item.coef_value = firc_pkg::sample_type'($urandom);
      item.sample     = value;
      offer(item);
   endtask

   task automatic send_coef(input coef_idx_type index, input firc_pkg::sample_type value);
      firc_pkg::req_type item;
      item.operation  = firc_pkg::OP_COEF;
      item.coef_index = index;
      item.coef_value = value;
      item.sample     = firc_pkg::sample_type'($urandom);
      offer(item);
   endtask

   // stop offering and wait until the filter has gone quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_taps(input firc_pkg::tap_count_type value);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // response side: random stall bursts, long ready stretches, one long hold-off
   initial begin : response_side
      int unsigned span;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_ch.ready <= 1'b0;
            long_hold_done = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            span = $urandom_range(1, 17);
            repeat (span) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            span = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            repeat (span) @(posedge clock);
         end
      end
   end

   // request side and verdict
   initial begin : stimulus
      int unsigned             phase_no;
      int unsigned             live;
      int unsigned             n_samples;
      firc_pkg::tap_count_type taps;
      shape_type               coef_shape;
      shape_type               sample_shape;

      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single tap from reset: zero bank, clipping, floor rounding
      send_sample(16'sd1234);
      send_coef(6'd0, firc_pkg::SAT_MIN);
      send_sample(firc_pkg::SAT_MIN);
      send_sample(firc_pkg::SAT_MAX);
      send_coef(6'd0, firc_pkg::SAT_MAX);
      send_sample(firc_pkg::SAT_MAX);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_coef(6'd63, firc_pkg::SAT_MIN);
      send_coef(6'd1, firc_pkg::SAT_MIN);

      // zero tap count gives zero
      drain();
      write_taps(7'd0);
      send_sample(firc_pkg::SAT_MAX);

      // tap count above the line length is clamped
      drain();
      write_taps(7'd127);
      send_sample(firc_pkg::SAT_MIN);

      // two full-scale taps clip both ways
      drain();
      write_taps(7'd2);
      send_coef(6'd0, firc_pkg::SAT_MIN);
      send_sample(firc_pkg::SAT_MIN);
      send_sample(firc_pkg::SAT_MIN);
      send_sample(firc_pkg::SAT_MAX);
      send_sample(firc_pkg::SAT_MAX);

      // random phases: load a coefficient set, then stream samples
      phase_no = 0;
      while (samples_sent + coefs_sent < ITEM_TARGET) begin
         drain();
         taps = phase_taps(phase_no);
         write_taps(taps);
         live = (taps > TAPS) ? TAPS : taps;
         coef_shape   = shape_type'($urandom_range(0, 4));
         sample_shape = shape_type'($urandom_range(0, 4));
         gap_odds     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);

         if ($urandom_range(0, 2) != 0) begin
            for (int k = 0; k < live; k++)
               send_coef(coef_idx_type'(k), word_of_shape(coef_shape));
         end else begin
            repeat ($urandom_range(1, 8))
               send_coef(coef_idx_type'($urandom_range(0, TAPS - 1)),
                         word_of_shape(coef_shape));
         end

         // once, keep offering while the response side holds off
         if (!long_hold_req && samples_sent >= 400) begin
            long_hold_req <= 1'b1;
            gap_odds = 0;
         end

         n_samples = $urandom_range(15, 60);
         repeat (n_samples) begin
            if ($urandom_range(0, 11) == 0)
               send_coef(coef_idx_type'($urandom_range(0, TAPS - 1)),
                         firc_pkg::sample_type'($urandom));
            else if ($urandom_range(0, 3) == 0)
               send_sample(word_of_shape(shape_type'($urandom_range(0, 4))));
            else
               send_sample(word_of_shape(sample_shape));
         end
         phase_no++;
      end
      drain();

      $display("covered %0d sample and %0d coefficient requests over %0d tap count writes",
               samples_sent, coefs_sent, settings_used);
      $display("%0d filter outputs checked, %0d of them clipped", checked_count, clipped_count);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS fir_filter_circular_delay");
      else
         $display("FAIL fir_filter_circular_delay");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/firc_pkg.sv
design/firc_if.sv
design/firc_cell.sv
design/firc_mac.sv
design/fir_filter_circular_delay.sv
verif/fir_filter_checker.sv
verif/tb.sv
